[design/fgtm_pkg.sv]
// Package: shared types, codes and constants of the single-precision matrix multiply block.
`timescale 1ns / 1ps
`default_nettype none
package fgtm_pkg;

    // Item modes.
    localparam logic [2:0] MODE_LOAD_A  = 3'd0;
    localparam logic [2:0] MODE_LOAD_B  = 3'd1;
    localparam logic [2:0] MODE_LOAD_C  = 3'd2;
    localparam logic [2:0] MODE_COMPUTE = 3'd3;
    localparam logic [2:0] MODE_READ_C  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ROWS_M      = 3'd0;
    localparam logic [2:0] CFG_COLS_N      = 3'd1;
    localparam logic [2:0] CFG_INNER_K     = 3'd2;
    localparam logic [2:0] CFG_ALPHA_BITS  = 3'd3;
    localparam logic [2:0] CFG_BETA_BITS   = 3'd4;
    localparam logic [2:0] CFG_TRANSPOSE_A = 3'd5;
    localparam logic [2:0] CFG_TRANSPOSE_B = 3'd6;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [31:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  result_row;
        logic [3:0]  result_col;
        logic [31:0] result_value;
    } out_item_t;

    typedef enum logic [1:0] {
        SEL_BETA_C,
        SEL_ALPHA_A,
        SEL_SCALED_B,
        SEL_ACC_PROD
    } fpu_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_C_FETCH,
        ST_SCALE_GO,
        ST_SCALE_WAIT,
        ST_AB_FETCH,
        ST_MUL1_GO,
        ST_MUL1_WAIT,
        ST_MUL2_GO,
        ST_MUL2_WAIT,
        ST_ADD_GO,
        ST_ADD_WAIT,
        ST_C_STORE
    } ctrl_state_t;

    typedef struct packed {
        logic     load_a;
        logic     load_b;
        logic     load_c;
        logic     read_c;
        logic     out_load;
        logic     rd_c;
        logic     rd_ab;
        logic     fpu_start;
        fpu_sel_t fpu_sel;
        logic     c_write;
        logic [3:0] r;
        logic [3:0] c;
        logic [3:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic fpu_done;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [3:0] m_last;
        logic [3:0] n_last;
        logic [3:0] k_last;
    } dims_t;

    typedef struct packed {
        logic [31:0] alpha;
        logic [31:0] beta;
        logic        ta;
        logic        tb;
    } dp_cfg_t;

endpackage
`default_nettype wire

[design/fgtm_fpu.sv]
// Three-stage IEEE single multiply or add unit, round to nearest even.
`timescale 1ns / 1ps
`default_nettype none
module fgtm_fpu
    import fgtm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic        is_add,
    input  wire logic [31:0] op_a,
    input  wire logic [31:0] op_b,
    output logic             done,
    output logic [31:0]      result
);

    logic               v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic               spec1_reg, spec1_next, spec2_reg;
    logic [31:0]        sval1_reg, sval1_next, sval2_reg;
    logic               s1_reg, s1_next, s2_reg;
    logic signed [10:0] e1_reg, e1_next, e2_reg;
    logic [49:0]        m1_reg, m1_next, m2_reg;
    logic [5:0]         lz_reg, lz_next;
    logic [31:0]        res_reg, res_next;

    // Stage one: unpack, special operands, then product or aligned sum.
    always_comb begin
        logic        sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big, eff_sub;
        logic [23:0] ma, mb, mx, my;
        logic signed [10:0] ea, eb, ex, ey, d;
        logic [5:0]  dsh;
        logic [99:0] sh;
        logic [49:0] xw, yw, sum;
        logic [47:0] prod;
        sa     = op_a[31];
        sb     = op_b[31];
        a_nan  = (op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0);
        b_nan  = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
        a_inf  = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
        b_inf  = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
        a_zero = (op_a[30:0] == 31'd0);
        b_zero = (op_b[30:0] == 31'd0);
        ma     = {op_a[30:23] != 8'd0, op_a[22:0]};
        mb     = {op_b[30:23] != 8'd0, op_b[22:0]};
        ea     = (op_a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, op_a[30:23]});
        eb     = (op_b[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, op_b[30:23]});
        a_big  = (ea > eb) || ((ea == eb) && (ma >= mb));
        mx     = a_big ? ma : mb;
        my     = a_big ? mb : ma;
        ex     = a_big ? ea : eb;
        ey     = a_big ? eb : ea;
        d      = ex - ey;
        dsh    = (d > 11'sd63) ? 6'd63 : d[5:0];
        eff_sub = sa ^ sb;
        xw     = {1'b0, mx, 25'd0};
        sh     = {1'b0, my, 25'd0, 50'd0} >> dsh;
        yw     = sh[99:50] | {49'd0, |sh[49:0]};
        sum    = eff_sub ? (xw - yw) : (xw + yw);
        prod   = ma * mb;

        spec1_next = 1'b1;
        sval1_next = FP_DEFAULT_NAN;
        if (a_nan) begin
            sval1_next = op_a | FP_QUIET_BIT;
        end else if (b_nan) begin
            sval1_next = op_b | FP_QUIET_BIT;
        end else if (!is_add && ((a_inf && b_zero) || (b_inf && a_zero))) begin
            sval1_next = FP_DEFAULT_NAN;
        end else if (!is_add && (a_inf || b_inf)) begin
            sval1_next = {sa ^ sb, 8'hFF, 23'd0};
        end else if (is_add && a_inf && b_inf && eff_sub) begin
            sval1_next = FP_DEFAULT_NAN;
        end else if (is_add && a_inf) begin
            sval1_next = op_a;
        end else if (is_add && b_inf) begin
            sval1_next = op_b;
        end else begin
            spec1_next = 1'b0;
        end

        if (is_add) begin
            m1_next = sum;
            e1_next = ex + 11'sd1;
            s1_next = (sum == 50'd0) ? (eff_sub ? 1'b0 : sa) : (a_big ? sa : sb);
        end else begin
            m1_next = {prod, 2'b00};
            e1_next = ea + eb - 11'sd126;
            s1_next = sa ^ sb;
        end
    end

    // Stage two: leading zero count.
    always_comb begin
        lz_next = 6'd0;
        for (int i = 0; i < 50; i++) begin
            if (m1_reg[i]) begin
                lz_next = 6'(49 - i);
            end
        end
    end

    // Stage three: normalise, denormalise, round and pack.
    always_comb begin
        logic signed [10:0] ep, shl, rs;
        logic [5:0]   rsc;
        logic [49:0]  n;
        logic [113:0] rw;
        logic         rst, up;
        logic [7:0]   expb;
        logic [30:0]  packed_mag;
        ep   = e2_reg - $signed({5'd0, lz_reg});
        shl  = e2_reg - 11'sd1;
        rs   = -shl;
        rsc  = (rs > 11'sd63) ? 6'd63 : rs[5:0];
        rw   = {m2_reg, 64'd0} >> rsc;
        rst  = 1'b0;
        expb = 8'd0;
        if (ep >= 11'sd1) begin
            n    = m2_reg << lz_reg;
            expb = ep[7:0];
        end else if (!shl[10]) begin
            n = m2_reg << shl[5:0];
        end else begin
            n   = rw[113:64];
            rst = |rw[63:0];
        end
        up         = n[25] & (rst | (|n[24:0]) | n[26]);
        packed_mag = {expb, n[48:26]} + {30'd0, up};
        if (spec2_reg) begin
            res_next = sval2_reg;
        end else if (m2_reg == 50'd0) begin
            res_next = {s2_reg, 31'd0};
        end else if (ep >= 11'sd255) begin
            res_next = {s2_reg, 8'hFF, 23'd0};
        end else begin
            res_next = {s2_reg, packed_mag};
        end
    end

    assign v1_next = start;
    assign v2_next = v1_reg;
    assign v3_next = v2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        spec1_reg <= spec1_next;
        sval1_reg <= sval1_next;
        s1_reg    <= s1_next;
        e1_reg    <= e1_next;
        m1_reg    <= m1_next;
        spec2_reg <= spec1_reg;
        sval2_reg <= sval1_reg;
        s2_reg    <= s1_reg;
        e2_reg    <= e1_reg;
        m2_reg    <= m1_reg;
        lz_reg    <= lz_next;
        res_reg   <= res_next;
    end

    assign done   = v3_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

[design/fgtm_datapath.sv]
// Datapath: operand stores, address generation, arithmetic unit, accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none
module fgtm_datapath
    import fgtm_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire dp_cmd_t   cmd,
    input  wire dp_cfg_t   cfg,
    input  wire in_item_t  s_data,
    input  wire logic      m_ready,
    output logic           m_valid,
    output out_item_t      m_data,
    output dp_stat_t       stat
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] DIM_W = AW'(MAX_DIM);
    localparam logic [6:0]    DIM_7 = 7'(MAX_DIM);

    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] c_mem [DEPTH];

    logic [31:0] a_rdata_reg, b_rdata_reg, c_rdata_reg;
    logic [31:0] acc_reg, tmp_reg;
    logic        rd_in_range_reg;
    logic [3:0]  rd_row_reg, rd_col_reg;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg;

    logic          in_range;
    logic [AW-1:0] in_addr, a_addr, b_addr, cc_addr, c_raddr;
    logic [31:0]   fpu_a, fpu_b, fpu_res;
    logic          fpu_done;

    function automatic logic [AW-1:0] grid_addr(input logic [3:0] row, input logic [3:0] col);
        return AW'(row) * DIM_W + AW'(col);
    endfunction

    assign in_range = ({3'd0, s_data.row_index} < DIM_7) && ({3'd0, s_data.col_index} < DIM_7);
    assign in_addr  = grid_addr(s_data.row_index, s_data.col_index);
    assign a_addr   = cfg.ta ? grid_addr(cmd.k, cmd.r) : grid_addr(cmd.r, cmd.k);
    assign b_addr   = cfg.tb ? grid_addr(cmd.c, cmd.k) : grid_addr(cmd.k, cmd.c);
    assign cc_addr  = grid_addr(cmd.r, cmd.c);
    assign c_raddr  = cmd.read_c ? in_addr : cc_addr;

    always_ff @(posedge aclk) begin
        if (cmd.load_a && in_range) begin
            a_mem[in_addr] <= s_data.element_value;
        end
        if (cmd.rd_ab) begin
            a_rdata_reg <= a_mem[a_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_b && in_range) begin
            b_mem[in_addr] <= s_data.element_value;
        end
        if (cmd.rd_ab) begin
            b_rdata_reg <= b_mem[b_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_c && in_range) begin
            c_mem[in_addr] <= s_data.element_value;
        end else if (cmd.c_write) begin
            c_mem[cc_addr] <= acc_reg;
        end
        if (cmd.read_c || cmd.rd_c) begin
            c_rdata_reg <= c_mem[c_raddr];
        end
    end

    always_comb begin
        case (cmd.fpu_sel)
            SEL_BETA_C: begin
                fpu_a = cfg.beta;
                fpu_b = c_rdata_reg;
            end
            SEL_ALPHA_A: begin
                fpu_a = cfg.alpha;
                fpu_b = a_rdata_reg;
            end
            SEL_SCALED_B: begin
                fpu_a = tmp_reg;
                fpu_b = b_rdata_reg;
            end
            SEL_ACC_PROD: begin
                fpu_a = acc_reg;
                fpu_b = tmp_reg;
            end
            default: begin
                fpu_a = acc_reg;
                fpu_b = tmp_reg;
            end
        endcase
    end

    fgtm_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.fpu_start),
        .is_add  (cmd.fpu_sel == SEL_ACC_PROD),
        .op_a    (fpu_a),
        .op_b    (fpu_b),
        .done    (fpu_done),
        .result  (fpu_res)
    );

    always_ff @(posedge aclk) begin
        if (fpu_done) begin
            if (cmd.fpu_sel == SEL_BETA_C || cmd.fpu_sel == SEL_ACC_PROD) begin
                acc_reg <= fpu_res;
            end else begin
                tmp_reg <= fpu_res;
            end
        end
        if (cmd.read_c) begin
            rd_in_range_reg <= in_range;
            rd_row_reg      <= s_data.row_index;
            rd_col_reg      <= s_data.col_index;
        end
        if (cmd.out_load) begin
            m_data_reg.result_row   <= rd_row_reg;
            m_data_reg.result_col   <= rd_col_reg;
            m_data_reg.result_value <= rd_in_range_reg ? c_rdata_reg : 32'd0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign stat.fpu_done = fpu_done;
    assign stat.out_busy = m_valid_reg && !m_ready;

endmodule
`default_nettype wire

[design/fgtm_controller.sv]
// Controller: state machine that sequences requests and the multiply-accumulate loops.
`timescale 1ns / 1ps
`default_nettype none
module fgtm_controller
    import fgtm_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire in_item_t  s_data,
    output logic           s_ready,
    input  wire dims_t     dims,
    input  wire dp_stat_t  stat,
    output dp_cmd_t        cmd
);

    ctrl_state_t state_reg, state_next;
    logic [3:0]  r_reg, r_next, c_reg, c_next, k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            r_reg     <= 4'd0;
            c_reg     <= 4'd0;
            k_reg     <= 4'd0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        k_next        = k_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.fpu_sel   = SEL_BETA_C;
        cmd.r         = r_reg;
        cmd.c         = c_reg;
        cmd.k         = k_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_data.mode)
                        MODE_LOAD_A:  cmd.load_a = 1'b1;
                        MODE_LOAD_B:  cmd.load_b = 1'b1;
                        MODE_LOAD_C:  cmd.load_c = 1'b1;
                        MODE_COMPUTE: state_next = ST_C_FETCH;
                        MODE_READ_C: begin
                            cmd.read_c = 1'b1;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_C_FETCH: begin
                cmd.rd_c   = 1'b1;
                state_next = ST_SCALE_GO;
            end
            ST_SCALE_GO: begin
                cmd.fpu_start = 1'b1;
                state_next    = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT: begin
                if (stat.fpu_done) begin
                    state_next = ST_AB_FETCH;
                end
            end
            ST_AB_FETCH: begin
                cmd.rd_ab  = 1'b1;
                state_next = ST_MUL1_GO;
            end
            ST_MUL1_GO: begin
                cmd.fpu_sel   = SEL_ALPHA_A;
                cmd.fpu_start = 1'b1;
                state_next    = ST_MUL1_WAIT;
            end
            ST_MUL1_WAIT: begin
                cmd.fpu_sel = SEL_ALPHA_A;
                if (stat.fpu_done) begin
                    state_next = ST_MUL2_GO;
                end
            end
            ST_MUL2_GO: begin
                cmd.fpu_sel   = SEL_SCALED_B;
                cmd.fpu_start = 1'b1;
                state_next    = ST_MUL2_WAIT;
            end
            ST_MUL2_WAIT: begin
                cmd.fpu_sel = SEL_SCALED_B;
                if (stat.fpu_done) begin
                    state_next = ST_ADD_GO;
                end
            end
            ST_ADD_GO: begin
                cmd.fpu_sel   = SEL_ACC_PROD;
                cmd.fpu_start = 1'b1;
                state_next    = ST_ADD_WAIT;
            end
            ST_ADD_WAIT: begin
                cmd.fpu_sel = SEL_ACC_PROD;
                if (stat.fpu_done) begin
                    if (k_reg == dims.k_last) begin
                        state_next = ST_C_STORE;
                    end else begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_AB_FETCH;
                    end
                end
            end
            ST_C_STORE: begin
                cmd.c_write = 1'b1;
                k_next      = 4'd0;
                if (c_reg != dims.n_last) begin
                    c_next     = c_reg + 4'd1;
                    state_next = ST_C_FETCH;
                end else if (r_reg != dims.m_last) begin
                    c_next     = 4'd0;
                    r_next     = r_reg + 4'd1;
                    state_next = ST_C_FETCH;
                end else begin
                    c_next     = 4'd0;
                    r_next     = 4'd0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The arithmetic unit only reports completion while a wait state expects it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.fpu_done |-> (state_reg == ST_SCALE_WAIT || state_reg == ST_MUL1_WAIT ||
                           state_reg == ST_MUL2_WAIT || state_reg == ST_ADD_WAIT))
        else $error("arithmetic result arrived outside a wait state");

    // Loop counters stay within the configured dimensions.
    a_counters_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_READ) |->
            (r_reg <= dims.m_last && c_reg <= dims.n_last && k_reg <= dims.k_last))
        else $error("loop counter beyond its dimension");

    // An element of C is written back only once the whole inner sum is done.
    a_store_after_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_C_STORE) |-> (k_reg == dims.k_last && $past(state_reg) == ST_ADD_WAIT))
        else $error("C written back before the inner sum finished");

endmodule
`default_nettype wire

[design/float_gemm_transpose_modes.sv]
// Top level of the single-precision matrix multiply with operand transposes.
`timescale 1ns / 1ps
`default_nettype none
// This block computes C = beta*C + alpha*op(A)*op(B) in IEEE single precision, with every
// multiply and add rounded to nearest even, where op() optionally transposes A or B. Requests
// on the input channel load one element of A, B or C at a stored row and column, start the
// compute, or read back one element of C; only a read returns a result. After a load the
// next request is taken in the following cycle. A read passes through a read state, as the
// C store has a registered read port, and waits there while the output register is full and
// not being taken; the result is held in that register so the next request is accepted while
// it waits to be taken. The compute request occupies the block until it is done: each C
// element fetches the old value, scales it by beta, runs each inner step as one operand fetch
// and three passes through the shared three-stage arithmetic unit, and is then written back.
// The dimensions are saturated to 1 .. min(16, MAX_DIM). Loads outside the store are dropped,
// and a read outside it returns zero. The stores are not cleared at reset, so every
// entry must be written before a compute or read uses it. Configuration may be written only
// while the block is idle.
module float_gemm_transpose_modes
    import fgtm_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    localparam int DIM_LIMIT = (MAX_DIM < 16) ? MAX_DIM : 16;

    // Configuration registers, reset to their defaults.
    logic [4:0]  rows_m_reg, cols_n_reg, inner_k_reg;
    logic [31:0] alpha_bits_reg, beta_bits_reg;
    logic        transpose_a_reg, transpose_b_reg;

    dims_t    dims;
    dp_cfg_t  dp_cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Saturates a dimension and returns its last index.
    function automatic logic [3:0] dim_last(input logic [4:0] v);
        logic [4:0] t;
        if (v == 5'd0) begin
            t = 5'd0;
        end else if (v > 5'(DIM_LIMIT)) begin
            t = 5'(DIM_LIMIT - 1);
        end else begin
            t = v - 5'd1;
        end
        return t[3:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg      <= 5'd16;
            cols_n_reg      <= 5'd16;
            inner_k_reg     <= 5'd16;
            alpha_bits_reg  <= 32'h3F80_0000;
            beta_bits_reg   <= 32'd0;
            transpose_a_reg <= 1'b0;
            transpose_b_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROWS_M:      rows_m_reg      <= cfg_wdata[4:0];
                CFG_COLS_N:      cols_n_reg      <= cfg_wdata[4:0];
                CFG_INNER_K:     inner_k_reg     <= cfg_wdata[4:0];
                CFG_ALPHA_BITS:  alpha_bits_reg  <= cfg_wdata;
                CFG_BETA_BITS:   beta_bits_reg   <= cfg_wdata;
                CFG_TRANSPOSE_A: transpose_a_reg <= cfg_wdata[0];
                CFG_TRANSPOSE_B: transpose_b_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign dims.m_last = dim_last(rows_m_reg);
    assign dims.n_last = dim_last(cols_n_reg);
    assign dims.k_last = dim_last(inner_k_reg);
    assign dp_cfg.alpha = alpha_bits_reg;
    assign dp_cfg.beta  = beta_bits_reg;
    assign dp_cfg.ta    = transpose_a_reg;
    assign dp_cfg.tb    = transpose_b_reg;

    // The controller steps through requests and loops; the datapath does the storage and sums.
    fgtm_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .dims    (dims),
        .stat    (stat),
        .cmd     (cmd)
    );

    fgtm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cfg     (dp_cfg),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .stat    (stat)
    );

endmodule
`default_nettype wire

[dv/float_gemm_transpose_modes_test.sv]
// Self-checking testbench for the single-precision matrix multiply block.
`timescale 1ns / 1ps
module float_gemm_transpose_modes_test;
    import fgtm_pkg::*;

    // Register index past the end of the list; the block must ignore writes to it.
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;
    // First of the three mode codes that the block ignores.
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [31:0] FP_ONE = 32'h3F80_0000;
    localparam logic [31:0] FP_POS_INF = 32'h7F80_0000;
    localparam int PHASE_COUNT = 12;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int PRESSURE_PHASE = 9;

    // The scoreboard keeps its own copy of the three stores and of the registers, and
    // works out the C element that every read request should return. Arithmetic is
    // done on the bit patterns, so rounding and special values match IEEE single exactly.
    class gemm_scoreboard;
        logic [31:0] a_mem [256];
        logic [31:0] b_mem [256];
        logic [31:0] c_mem [256];
        logic [4:0]  rows_m, cols_n, inner_k;
        logic [31:0] alpha, beta;
        bit          trans_a, trans_b;
        out_item_t   read_q [$];
        int          errors;

        function new();
            rows_m = 5'd16;
            cols_n = 5'd16;
            inner_k = 5'd16;
            alpha = FP_ONE;
            beta = '0;
            trans_a = 0;
            trans_b = 0;
            errors = 0;
            foreach (a_mem[i]) begin
                a_mem[i] = '0;
                b_mem[i] = '0;
                c_mem[i] = '0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_ROWS_M:      rows_m = val[4:0];
                CFG_COLS_N:      cols_n = val[4:0];
                CFG_INNER_K:     inner_k = val[4:0];
                CFG_ALPHA_BITS:  alpha = val;
                CFG_BETA_BITS:   beta = val;
                CFG_TRANSPOSE_A: trans_a = val[0];
                CFG_TRANSPOSE_B: trans_b = val[0];
                default: ;
            endcase
        endfunction

        function int sat_dim(logic [4:0] v);
            if (v == 0) return 1;
            if (v > 16) return 16;
            return int'(v);
        endfunction

        function int compute_cycles();
            return sat_dim(rows_m) * sat_dim(cols_n) * (6 + 13 * sat_dim(inner_k));
        endfunction

        function int pending();
            return read_q.size();
        endfunction

        function bit is_nan(logic [31:0] x);
            return x[30:23] == 8'hFF && x[22:0] != 0;
        endfunction

        function bit is_inf(logic [31:0] x);
            return x[30:0] == FP_POS_INF[30:0];
        endfunction

        function bit is_zero(logic [31:0] x);
            return x[30:0] == 0;
        endfunction

        // Value of x is mant * 2**e.
        function void split(logic [31:0] x, output int e, output logic [63:0] mant);
            if (x[30:23] == 0) begin
                mant = {41'd0, x[22:0]};
                e = -149;
            end else begin
                mant = {40'd0, 1'b1, x[22:0]};
                e = int'(x[30:23]) - 150;
            end
        endfunction

        // Rounds sign * mant * 2**e to single precision, nearest even.
        function logic [31:0] round_pack(bit s, int e, logic [63:0] mant);
            int p, ue, biased, sh;
            logic [63:0] m, w;
            bit g, st;
            if (mant == 0) return {s, 31'd0};
            p = 63;
            while (!mant[p]) p--;
            ue = p + e;
            if (ue > 127) return {s, FP_POS_INF[30:0]};
            if (ue >= -126) begin
                biased = ue + 127;
                sh = p - 23;
            end else begin
                biased = 1;
                sh = -149 - e;
            end
            g = 0;
            st = 0;
            if (sh <= 0) begin
                m = mant << (-sh);
            end else if (sh > 64) begin
                m = 0;
                st = 1;
            end else begin
                m = mant >> sh;
                g = mant[sh - 1];
                st = (sh > 1) ? |(mant & ((64'd1 << (sh - 1)) - 1)) : 1'b0;
            end
            if (g && (st || m[0])) m = m + 1;
            w = (64'(biased - 1) << 23) + m;
            if (w >= 64'(FP_POS_INF)) return {s, FP_POS_INF[30:0]};
            return {s, w[30:0]};
        endfunction

        function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
            int ea, eb;
            logic [63:0] ma, mb;
            bit s;
            if (is_nan(a)) return a | FP_QUIET_BIT;
            if (is_nan(b)) return b | FP_QUIET_BIT;
            s = a[31] ^ b[31];
            if (is_inf(a) || is_inf(b)) begin
                if (is_zero(a) || is_zero(b)) return FP_DEFAULT_NAN;
                return {s, FP_POS_INF[30:0]};
            end
            split(a, ea, ma);
            split(b, eb, mb);
            return round_pack(s, ea + eb, ma * mb);
        endfunction

        function logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
            int ea, eb, el, d;
            logic [63:0] ma, mb, ml, ms, big, tiny;
            bit sl;
            if (is_nan(a)) return a | FP_QUIET_BIT;
            if (is_nan(b)) return b | FP_QUIET_BIT;
            if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? FP_DEFAULT_NAN : a;
            if (is_inf(a)) return a;
            if (is_inf(b)) return b;
            if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
            if (is_zero(a)) return b;
            if (is_zero(b)) return a;
            split(a, ea, ma);
            split(b, eb, mb);
            if (ea > eb || (ea == eb && ma >= mb)) begin
                el = ea; ml = ma; sl = a[31]; d = ea - eb; ms = mb;
            end else begin
                el = eb; ml = mb; sl = b[31]; d = eb - ea; ms = ma;
            end
            // The larger operand gets 30 spare bits below it; anything of the smaller
            // one that falls off the bottom only matters as a sticky bit.
            big = ml << 30;
            if (d <= 30) tiny = ms << (30 - d);
            else if (d - 30 >= 64) tiny = 64'd1;
            else tiny = (ms >> (d - 30)) | 64'(|(ms & ((64'd1 << (d - 30)) - 1)));
            if (a[31] == b[31]) return round_pack(sl, el - 30, big + tiny);
            if (big == tiny) return 32'd0;
            return round_pack(sl, el - 30, big - tiny);
        endfunction

        function void multiply_all();
            int m, n, kk;
            logic [31:0] acc, scaled;
            logic [7:0] ai, bi, ci;
            m = sat_dim(rows_m);
            n = sat_dim(cols_n);
            kk = sat_dim(inner_k);
            for (int r = 0; r < m; r++) begin
                for (int c = 0; c < n; c++) begin
                    ci = {4'(r), 4'(c)};
                    acc = fp_mul(beta, c_mem[ci]);
                    for (int k = 0; k < kk; k++) begin
                        ai = trans_a ? {4'(k), 4'(r)} : {4'(r), 4'(k)};
                        bi = trans_b ? {4'(c), 4'(k)} : {4'(k), 4'(c)};
                        scaled = fp_mul(alpha, a_mem[ai]);
                        acc = fp_add(acc, fp_mul(scaled, b_mem[bi]));
                    end
                    c_mem[ci] = acc;
                end
            end
        endfunction

        function void note_request(in_item_t it);
            logic [7:0] idx;
            out_item_t res;
            idx = {it.row_index, it.col_index};
            case (it.mode)
                MODE_LOAD_A:  a_mem[idx] = it.element_value;
                MODE_LOAD_B:  b_mem[idx] = it.element_value;
                MODE_LOAD_C:  c_mem[idx] = it.element_value;
                MODE_COMPUTE: multiply_all();
                MODE_READ_C: begin
                    res.result_row = it.row_index;
                    res.result_col = it.col_index;
                    res.result_value = c_mem[idx];
                    read_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (read_q.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d value %h", $time,
                         got.result_row, got.result_col, got.result_value);
                errors++;
                return;
            end
            want = read_q.pop_front();
            if (got.result_row !== want.result_row) begin
                $display("%0t: result_row expected %0d actual %0d", $time,
                         want.result_row, got.result_row);
                errors++;
            end
            if (got.result_col !== want.result_col) begin
                $display("%0t: result_col expected %0d actual %0d", $time,
                         want.result_col, got.result_col);
                errors++;
            end
            if (got.result_value !== want.result_value) begin
                $display("%0t: result_value expected %h actual %h", $time,
                         want.result_value, got.result_value);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    gemm_scoreboard sb;
    int  send_idle_pct = 25;
    int  recv_idle_pct = 80;
    int  hold_cycles = 0;
    bit  compute_sent = 0;
    int  compute_budget;

    float_gemm_transpose_modes u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #4 aclk = ~aclk;

    // A float with a modest exponent, so that products and sums stay finite and the
    // rounding of ordinary values gets most of the exercise.
    function automatic logic [31:0] modest_float();
        return {1'($urandom_range(1)), 8'($urandom_range(134, 120)), 23'($urandom)};
    endfunction

    // Element values: mostly modest numbers, with signed zeros, subnormals, huge values,
    // infinities, quiet and signalling NaNs and raw random patterns mixed in.
    function automatic logic [31:0] pick_element();
        case ($urandom_range(11))
            6:  return {1'($urandom_range(1)), 31'd0};
            7:  return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
            8:  return {1'($urandom_range(1)), 8'($urandom_range(254, 240)), 23'($urandom)};
            9:  return {1'($urandom_range(1)), 8'hFF,
                        ($urandom_range(3) == 0) ? 23'd0 : 23'($urandom | 1)};
            10: return $urandom;
            default: return modest_float();
        endcase
    endfunction

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(9))
            0: return FP_ONE;
            1: return 32'd0;
            2: return 32'hBF80_0000;
            3: return 32'h4020_0000;
            4: return $urandom;
            5: return pick_element();
            default: return modest_float();
        endcase
    endfunction

    // Results are taken on the edge at which m_valid and m_ready are both high. The
    // ready for the next edge is chosen afterwards, or held low through a long stall.
    initial begin
        sb = new();
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) sb.check_result(m_data);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one request and waits for it to be taken. Valid is only dropped when a gap
    // is chosen, so back-to-back requests keep it high without a glitch.
    task automatic send_request(in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(it);
        if (it.mode == MODE_COMPUTE) compute_sent = 1;
    endtask

    task automatic send_fields(logic [2:0] mode, int row, int col, logic [31:0] value);
        in_item_t it;
        it.mode = mode;
        it.row_index = 4'(row);
        it.col_index = 4'(col);
        it.element_value = value;
        send_request(it);
    endtask

    // Stops offering, waits for every outstanding read to come back, and then lets a
    // compute that may still be running finish before anything else happens.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (compute_sent ? sb.compute_cycles() + 20 : 4) @(posedge aclk);
        compute_sent = 0;
    endtask

    // Writes every register, plus the spare index, on consecutive edges.
    task automatic write_config(logic [4:0] m, logic [4:0] n, logic [4:0] k,
                                logic [31:0] al, logic [31:0] be, bit ta, bit tb);
        logic [31:0] vals [8];
        vals[CFG_ROWS_M] = {27'd0, m};
        vals[CFG_COLS_N] = {27'd0, n};
        vals[CFG_INNER_K] = {27'd0, k};
        vals[CFG_ALPHA_BITS] = al;
        vals[CFG_BETA_BITS] = be;
        vals[CFG_TRANSPOSE_A] = {31'd0, ta};
        vals[CFG_TRANSPOSE_B] = {31'd0, tb};
        vals[CFG_SPARE_INDEX] = $urandom;
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(3'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One random request. Large dimensions make a compute expensive, so the number of
    // computes per phase is capped by compute_budget.
    task automatic send_random(bit mostly_reads);
        int pick;
        logic [2:0] mode;
        pick = $urandom_range(99);
        if (mostly_reads) pick = (pick < 10) ? pick * 4 : 60;
        if (pick < 45) mode = MODE_LOAD_A + 3'($urandom_range(2));
        else if (pick < 85) mode = MODE_READ_C;
        else if (pick < 89 && compute_budget > 0) begin
            mode = MODE_COMPUTE;
            compute_budget--;
        end else if (pick < 95) mode = MODE_UNUSED_FIRST + 3'($urandom_range(2));
        else mode = MODE_READ_C;
        send_fields(mode, $urandom_range(15), $urandom_range(15), pick_element());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every store entry is written before anything reads it; the block does not
        // clear its stores at reset.
        for (int mem = 0; mem < 3; mem++)
            for (int r = 0; r < 16; r++)
                for (int c = 0; c < 16; c++)
                    send_fields(MODE_LOAD_A + 3'(mem), r, c, pick_element());

        // Directed part: corner reads, the default full-size compute with the reset
        // registers, ignored modes with all field bits set or clear, and loads of extreme values.
        send_fields(MODE_READ_C, 0, 0, '0);
        send_fields(MODE_READ_C, 15, 15, '1);
        send_fields(MODE_COMPUTE, 0, 0, '0);
        send_fields(MODE_READ_C, 15, 15, '0);
        send_fields(MODE_READ_C, 0, 15, '0);
        send_fields(MODE_READ_C, 15, 0, '0);
        send_fields(MODE_UNUSED_FIRST, 15, 15, '1);
        send_fields(MODE_UNUSED_FIRST + 3'd1, 0, 0, '0);
        send_fields(MODE_UNUSED_FIRST + 3'd2, 15, 15, '1);
        send_fields(MODE_LOAD_C, 15, 15, '1);
        send_fields(MODE_LOAD_C, 0, 0, '0);
        send_fields(MODE_READ_C, 15, 15, '0);
        send_fields(MODE_READ_C, 0, 0, '1);
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            // Idling pattern: sender-light then receiver-light, then no idling at all.
            if (ph < 4) begin
                send_idle_pct = 25;
                recv_idle_pct = 80;
            end else if (ph < 8) begin
                send_idle_pct = 80;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            compute_budget = 3;
            case (ph)
                0: write_config(5'd1, 5'd1, 5'd1, 32'd0, 32'hFFFF_FFFF, 0, 0);
                1: write_config(5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'd0, 1, 1);
                2: begin
                    write_config(5'd31, 5'd31, 5'd31, FP_ONE, FP_ONE, 1, 1);
                    compute_budget = 1;
                end
                3: begin
                    write_config(5'd16, 5'd1, 5'd16, 32'hC020_0000, 32'h3F00_0000, 1, 0);
                    compute_budget = 2;
                end
                default: write_config(5'($urandom_range(4, 1)), 5'($urandom_range(4, 1)),
                                      5'($urandom_range(5, 1)), pick_scale(), pick_scale(),
                                      1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            // In the pressure phase the receiver stalls for a long stretch while reads keep
            // coming, so the output register fills and the input channel backs up.
            if (ph == PRESSURE_PHASE) hold_cycles = 400;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random(ph == PRESSURE_PHASE);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
